FILE: hw/rtl/ordered_list_insert_delete_core_defines.svh
// Assertion macros shared by the ordered list core.
`ifndef ORDERED_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define OLID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define OLID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/olid_pkg.sv
// Types and codes shared by the ordered list core and its cells.
`default_nettype none

package olid_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ENTRY_COUNT_W = 5;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 8;

  typedef enum logic [1:0] {
    FN_PUSH_FRONT = 2'd0,
    FN_PUSH_BACK  = 2'd1,
    FN_DELETE     = 2'd2,
    FN_NOP        = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MATCH,
    PH_APPLY
  } phase_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                  match_en;
    logic                  apply_en;
    func_t                 func;
    logic [VALUE_W-1:0]    value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/olid_cell.sv
// One list position: holds an entry, its occupied flag and a match flag.
`default_nettype none

module olid_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire olid_pkg::cell_ctrl_t         ctrl,
  input  wire logic [olid_pkg::VALUE_W-1:0] left_entry,
  input  wire logic                         left_used,
  input  wire logic [olid_pkg::VALUE_W-1:0] right_entry,
  input  wire logic                         right_used,
  input  wire logic                         hit_in,
  output logic [olid_pkg::VALUE_W-1:0]      entry,
  output logic                              used,
  output logic                              hit_out
);

  logic match;

  // a match at or in front of this cell: this cell closes up from the right
  assign hit_out = hit_in | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.match_en) begin
        match <= used && (entry == ctrl.value);
      end
      if (ctrl.apply_en) begin
        unique case (ctrl.func)
          olid_pkg::FN_PUSH_FRONT: used <= left_used;
          olid_pkg::FN_PUSH_BACK: begin
            if (!used && left_used) used <= 1'b1;
          end
          olid_pkg::FN_DELETE: begin
            if (hit_out) used <= right_used;
          end
          olid_pkg::FN_NOP: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.apply_en) begin
      unique case (ctrl.func)
        olid_pkg::FN_PUSH_FRONT: entry <= left_entry;
        olid_pkg::FN_PUSH_BACK: begin
          if (!used && left_used) entry <= ctrl.value;
        end
        olid_pkg::FN_DELETE: begin
          if (hit_out) entry <= right_entry;
        end
        olid_pkg::FN_NOP: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ordered_list_insert_delete_core.sv
// Top level of the ordered list core: request control, count and the row of cells.
//
//  channel  dir  beat contents (tdata, lowest bit up)
//  s_axis   in   func[1:0], value[33:2], zero pad[39:34]
//  m_axis   out  status[1:0], entry_count[6:2], zero pad[7]
//
// One request at a time: accept, compare in every cell, then apply and
// register the result before the next request is accepted.
// The compare cycle registers each cell's match; the apply cycle ripples the
// first-match flag down the row of cells and shifts entries in one step.
// A result waiting at m_axis holds the apply cycle until it is taken.
// rst (synchronous) empties the list; entry contents are not cleared.
`default_nettype none
`include "ordered_list_insert_delete_core_defines.svh"

module ordered_list_insert_delete_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [olid_pkg::S_TDATA_W-1:0] s_tdata,  // func[1:0], value[33:2]
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [olid_pkg::M_TDATA_W-1:0]      m_tdata   // status[1:0], entry_count[6:2]
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned VW = olid_pkg::VALUE_W;
  localparam int unsigned ECW = olid_pkg::ENTRY_COUNT_W;

  olid_pkg::phase_t     phase, phase_next;
  olid_pkg::func_t      req_func;
  logic [VW-1:0]        req_value;
  logic [CNT_W-1:0]     count, count_next;
  olid_pkg::status_t    status;
  olid_pkg::cell_ctrl_t ctrl;

  logic out_free;
  logic match_go;
  logic apply_go;
  logic full;
  logic empty;
  logic found;

  logic [VW-1:0]     entry_q [CAPACITY];
  logic [CAPACITY-1:0] used_vec;
  logic [CAPACITY:0]   hit;
  logic [CNT_W+ECW-1:0] cnt_ext;

  assign out_free = !m_tvalid || m_tready;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign found    = hit[CAPACITY];

  // ---- phase control ----
  always_comb begin
    phase_next = phase;
    unique case (phase)
      olid_pkg::PH_IDLE:  if (s_tvalid) phase_next = olid_pkg::PH_MATCH;
      olid_pkg::PH_MATCH: phase_next = olid_pkg::PH_APPLY;
      olid_pkg::PH_APPLY: if (out_free) phase_next = olid_pkg::PH_IDLE;
      default:            phase_next = olid_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    match_go = 1'b0;
    apply_go = 1'b0;
    unique case (phase)
      olid_pkg::PH_IDLE:  s_tready = 1'b1;
      olid_pkg::PH_MATCH: match_go = 1'b1;
      olid_pkg::PH_APPLY: apply_go = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= olid_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_func <= olid_pkg::FN_NOP;
    end else if (s_tvalid && s_tready) begin
      req_func <= olid_pkg::func_t'(s_tdata[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_value <= s_tdata[VW+1:2];
    end
  end

  // ---- status and count ----
  always_comb begin
    status     = olid_pkg::STAT_OK;
    count_next = count;
    unique case (req_func) inside
      olid_pkg::FN_PUSH_FRONT, olid_pkg::FN_PUSH_BACK: begin
        if (full) status = olid_pkg::STAT_FULL;
        else count_next = count + CNT_W'(1);
      end
      olid_pkg::FN_DELETE: begin
        if (empty) status = olid_pkg::STAT_EMPTY;
        else if (!found) status = olid_pkg::STAT_NOT_FOUND;
        else count_next = count - CNT_W'(1);
      end
      olid_pkg::FN_NOP: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply_go) begin
      count <= count_next;
    end
  end

  // ---- row of cells ----
  always_comb begin
    ctrl.match_en = match_go;
    ctrl.apply_en = apply_go && ((req_func == olid_pkg::FN_DELETE) || !full);
    ctrl.func     = req_func;
    ctrl.value    = req_value;
  end

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0] left_entry;
    logic          left_used;
    logic [VW-1:0] right_entry;
    logic          right_used;

    if (i == 0) begin : g_head
      // the head takes the request value on a push at the front or onto an empty list
      assign left_entry = req_value;
      assign left_used  = 1'b1;
    end else begin : g_body
      assign left_entry = entry_q[i-1];
      assign left_used  = used_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
      assign right_used  = 1'b0;
    end else begin : g_inner
      assign right_entry = entry_q[i+1];
      assign right_used  = used_vec[i+1];
    end

    olid_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_entry  (left_entry),
      .left_used   (left_used),
      .right_entry (right_entry),
      .right_used  (right_used),
      .hit_in      (hit[i]),
      .entry       (entry_q[i]),
      .used        (used_vec[i]),
      .hit_out     (hit[i+1])
    );
  end

  // ---- result register ----
  assign cnt_ext = {{ECW{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (apply_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      m_tdata <= {1'b0, cnt_ext[ECW-1:0], status};
    end
  end

  // ---- checks ----
  `OLID_ASSERT_NOW(a_used_packed, 1'b1, ((used_vec & (used_vec + CAPACITY'(1))) == '0), "occupied cells not packed at front")
  `OLID_ASSERT_NOW(a_used_count, 1'b1, ($countones(used_vec) == int'(count)), "occupied cells disagree with count")
  `OLID_ASSERT_NEXT(a_delete_shrinks, (apply_go && (req_func == olid_pkg::FN_DELETE) && found), (count == $past(count) - CNT_W'(1)), "delete with match did not shrink count")

endmodule

`default_nettype wire
